[rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions of the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    // Parser modes.
    localparam logic [1:0] MODE_WAIT = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_U     = 8'h75;

    // UTF-8 encoding constants.
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [15:0] UTF8_2B_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_3B_LIMIT = 16'h0800;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  hex_count;
        logic [15:0] code_point;
        logic        hex_stopped;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        mode: MODE_WAIT, hex_count: 2'd0, code_point: 16'd0, hex_stopped: 1'b0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [COUNT_W-1:0]        count;
    } burst_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data);
        result_t r;
        r.kind = kind;
        r.data = (kind == KIND_DATA) ? data : 8'd0;
        return r;
    endfunction

endpackage

[rtl/jsu_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Combinational step of the parser: one byte and the current state give the
// next state and a burst of up to four results.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   in_byte,
    input  logic         end_of_input,
    output parse_state_t next_state,
    output burst_t       burst
);

    always_comb begin
        parse_state_t       st;
        burst_t             b;
        logic [COUNT_W-1:0] n;
        logic               closed;
        logic               err;
        logic [4:0]         hv;
        logic [15:0]        cp;

        st     = cur_state;
        b      = '0;
        n      = '0;
        closed = 1'b0;
        err    = 1'b0;
        hv     = hex_digit(in_byte);
        cp     = 16'd0;

        unique case (cur_state.mode)
            MODE_STR: begin
                if (in_byte == CH_QUOTE) begin
                    b.res[n[1:0]] = make_result(KIND_CLOSE, 8'd0);
                    n = n + 1'b1;
                    st.mode = MODE_WAIT;
                    closed = 1'b1;
                end else if (in_byte == CH_BSLASH) begin
                    st.mode = MODE_ESC;
                end else begin
                    b.res[n[1:0]] = make_result(KIND_DATA, in_byte);
                    n = n + 1'b1;
                end
            end
            MODE_ESC: begin
                if (in_byte == CH_U) begin
                    st.mode        = MODE_HEX;
                    st.hex_count   = 2'd0;
                    st.code_point  = 16'd0;
                    st.hex_stopped = 1'b0;
                end else begin
                    b.res[n[1:0]] = make_result(KIND_DATA, map_escape(in_byte));
                    n = n + 1'b1;
                    st.mode = MODE_STR;
                end
            end
            MODE_HEX: begin
                if (!cur_state.hex_stopped && hv[4]) begin
                    st.code_point = {cur_state.code_point[11:0], hv[3:0]};
                end else begin
                    st.hex_stopped = 1'b1;
                end
                if (cur_state.hex_count == 2'd3) begin
                    // Fourth byte: encode the accumulated value as UTF-8.
                    cp = st.code_point;
                    if (cp < UTF8_2B_LIMIT) begin
                        b.res[n[1:0]] = make_result(KIND_DATA, cp[7:0]);
                        n = n + 1'b1;
                    end else if (cp < UTF8_3B_LIMIT) begin
                        b.res[n[1:0]] = make_result(KIND_DATA, UTF8_LEAD2 | {3'd0, cp[10:6]});
                        n = n + 1'b1;
                        b.res[n[1:0]] = make_result(KIND_DATA, UTF8_CONT | {2'd0, cp[5:0]});
                        n = n + 1'b1;
                    end else begin
                        b.res[n[1:0]] = make_result(KIND_DATA, UTF8_LEAD3 | {4'd0, cp[15:12]});
                        n = n + 1'b1;
                        b.res[n[1:0]] = make_result(KIND_DATA, UTF8_CONT | {2'd0, cp[11:6]});
                        n = n + 1'b1;
                        b.res[n[1:0]] = make_result(KIND_DATA, UTF8_CONT | {2'd0, cp[5:0]});
                        n = n + 1'b1;
                    end
                    st.mode      = MODE_STR;
                    st.hex_count = 2'd0;
                end else begin
                    st.hex_count = cur_state.hex_count + 2'd1;
                end
            end
            default: begin
                if (in_byte == CH_QUOTE) begin
                    st.mode = MODE_STR;
                end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
                             in_byte != CH_LF && in_byte != CH_CR) begin
                    err     = 1'b1;
                    st.mode = MODE_WAIT;
                end
            end
        endcase

        // A stray byte, or a buffer that ends outside a closed string, adds one error.
        if (err || (end_of_input && !closed)) begin
            b.res[n[1:0]] = make_result(KIND_ERROR, 8'd0);
            n = n + 1'b1;
        end
        if (end_of_input) begin
            st = STATE_RESET;
        end

        b.count    = n;
        next_state = st;
        burst      = b;
    end

endmodule

[rtl/jsu_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds the burst of one byte and shifts it out one
// transfer at a time on the master stream.
// ----------------------------------------------------------------------------
module jsu_out_buf
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst,
    output logic       can_load,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [COUNT_W-1:0]        rem_reg;

    assign m_axis_tvalid = (rem_reg != '0);
    assign m_axis_tdata  = res_reg[0].data;
    assign m_axis_tuser  = res_reg[0].kind;
    assign m_axis_tlast  = (rem_reg == COUNT_W'(1));

    // Free now, or the final result of the current burst leaves this cycle.
    assign can_load = (rem_reg == '0) || (m_axis_tlast && m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= burst.count;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= burst.res;
        end else if (m_axis_tvalid && m_axis_tready) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                res_reg[i] <= res_reg[i+1];
            end
            res_reg[MAX_RESULTS-1] <= '0;
        end
    end

endmodule

[rtl/json_string_unescape_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Path: an input transfer passes through the input register, then the result register.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is not stalled; a byte with more results holds the input until the last leaves.
// Reset: synchronous active-low aresetn clears the parser to wait for a quote
// and empties both the input and result registers.
// ----------------------------------------------------------------------------
module json_string_unescape_unit
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_end_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    burst_t       burst;
    logic         can_load;
    logic         advance;

    // The registered byte moves into the result register when that is free.
    assign advance       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    jsu_decode u_decode (
        .cur_state    (state_reg),
        .in_byte      (in_byte_reg),
        .end_of_input (in_end_reg),
        .next_state   (state_next),
        .burst        (burst)
    );

    jsu_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .burst         (burst),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A byte held back by a busy result register keeps its value.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_end_reg)))
        else $error("held input byte changed");

    // An error always closes the burst of its byte.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |-> m_axis_tlast)
        else $error("error result not last in burst");

    // Only data results carry a byte.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> (m_axis_tdata == 8'd0))
        else $error("non-data result with nonzero byte");

    // The parser state only moves when a byte is consumed.
    a_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without a byte");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON string unescape unit. A short directed
// stream covers whitespace, stray bytes, byte extremes, escapes, \u escapes
// cut short and the widest burst of results. Random quoted strings, noise and
// truncated input follow under four idling mixes. A behavioral decoder in
// this file predicts every result transfer, and a checker compares them in
// order.
// ----------------------------------------------------------------------------
module tb_top
    import jsu_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_last;
    } decoded_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;   // end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic [1:0] m_axis_tuser;          // [1:0] kind
    logic       m_axis_tlast;          // last

    // Decoder state mirrored from the block.
    logic [1:0]  dec_mode = MODE_WAIT;
    logic [1:0]  dec_hex_count = 2'd0;
    logic [15:0] dec_code_point = 16'd0;
    logic        dec_hex_stopped = 1'b0;

    decoded_t   decoded_q[$];
    decoded_t   step_q[$];
    logic [7:0] text_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int n_data = 0;
    int n_close = 0;
    int n_error = 0;
    int n_utf8_1 = 0;
    int n_utf8_2 = 0;
    int n_utf8_3 = 0;

    always #4 aclk = ~aclk;

    json_string_unescape_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] lower;
        lower = c | 8'h20;
        v = 4'd0;
        hex_nibble = 1'b1;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
        end else if (lower >= "a" && lower <= "f") begin
            v = c[3:0] + 4'd9;
        end else begin
            hex_nibble = 1'b0;
        end
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        case (c)
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            default: return c;
        endcase
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] data);
        decoded_t r;
        r.kind = kind;
        r.data = (kind == KIND_DATA) ? data : 8'd0;
        r.is_last = 1'b0;
        step_q.push_back(r);
    endfunction

    function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
        logic       closed;
        logic       stray;
        logic       is_hex;
        logic [3:0] nib;
        logic [15:0] cp;
        closed = 1'b0;
        stray = 1'b0;
        step_q.delete();
        case (dec_mode)
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    add_result(KIND_CLOSE, 8'd0);
                    dec_mode = MODE_WAIT;
                    closed = 1'b1;
                end else if (c == CH_BSLASH) begin
                    dec_mode = MODE_ESC;
                end else begin
                    add_result(KIND_DATA, c);
                end
            end
            MODE_ESC: begin
                if (c == CH_U) begin
                    dec_mode = MODE_HEX;
                    dec_hex_count = 2'd0;
                    dec_code_point = 16'd0;
                    dec_hex_stopped = 1'b0;
                end else begin
                    add_result(KIND_DATA, escape_byte(c));
                    dec_mode = MODE_STR;
                end
            end
            MODE_HEX: begin
                is_hex = hex_nibble(c, nib);
                if (!dec_hex_stopped && is_hex) begin
                    dec_code_point = {dec_code_point[11:0], nib};
                end else begin
                    dec_hex_stopped = 1'b1;
                end
                if (dec_hex_count == 2'd3) begin
                    cp = dec_code_point;
                    if (cp < 16'h0080) begin
                        add_result(KIND_DATA, cp[7:0]);
                        n_utf8_1++;
                    end else if (cp < 16'h0800) begin
                        add_result(KIND_DATA, 8'hC0 | {3'd0, cp[10:6]});
                        add_result(KIND_DATA, 8'h80 | {2'd0, cp[5:0]});
                        n_utf8_2++;
                    end else begin
                        add_result(KIND_DATA, 8'hE0 | {4'd0, cp[15:12]});
                        add_result(KIND_DATA, 8'h80 | {2'd0, cp[11:6]});
                        add_result(KIND_DATA, 8'h80 | {2'd0, cp[5:0]});
                        n_utf8_3++;
                    end
                    dec_mode = MODE_STR;
                    dec_hex_count = 2'd0;
                end else begin
                    dec_hex_count = dec_hex_count + 2'd1;
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    dec_mode = MODE_STR;
                end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
                    stray = 1'b1;
                end
            end
        endcase
        if (stray || (eoi && !closed)) begin
            add_result(KIND_ERROR, 8'd0);
        end
        if (eoi) begin
            dec_mode = MODE_WAIT;
            dec_hex_count = 2'd0;
            dec_code_point = 16'd0;
            dec_hex_stopped = 1'b0;
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size()-1].is_last = 1'b1;
        end
        foreach (step_q[i]) begin
            decoded_q.push_back(step_q[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        unescape_byte(c, eoi);
        bytes_sent++;
    endtask

    // Sends the staged text; the byte at end_at carries end of input and
    // anything after it is dropped. A negative end_at sends it all.
    task automatic send_text(input int end_at);
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == end_at);
            if (i == end_at) break;
        end
        text_q.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'h30 + {4'd0, nib};
        return (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] whitespace_char();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void add_unicode_escape();
        logic [15:0] cp;
        int          bad_pos;
        case ($urandom_range(2))
            0:       cp = 16'($urandom_range(16'h007F, 0));
            1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
            default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        // Now and then one position holds an arbitrary byte, which may stop
        // the digit reading early.
        bad_pos = ($urandom_range(4) == 0) ? $urandom_range(3) : 4;
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 0; i < 4; i++) begin
            if (i == bad_pos) begin
                text_q.push_back(8'($urandom_range(255)));
            end else begin
                text_q.push_back(hex_char(cp[15-4*i -: 4], 1'($urandom_range(1))));
            end
        end
    endfunction

    function automatic void build_string(input int tokens);
        logic [7:0] c;
        repeat ($urandom_range(2)) text_q.push_back(whitespace_char());
        text_q.push_back(CH_QUOTE);
        repeat (tokens) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
                    text_q.push_back(c);
                end
                4, 5: begin
                    case ($urandom_range(7))
                        0:       c = CH_QUOTE;
                        1:       c = CH_BSLASH;
                        2:       c = "/";
                        3:       c = "b";
                        4:       c = "f";
                        5:       c = "n";
                        6:       c = "r";
                        default: c = "t";
                    endcase
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(c);
                end
                6: begin
                    do c = 8'($urandom_range(255)); while (c == CH_U);
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(c);
                end
                default: add_unicode_escape();
            endcase
        end
        text_q.push_back(CH_QUOTE);
    endfunction

    task automatic set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Whitespace, a stray NUL, byte extremes inside a string, a simple
        // escape, then \uFFFF ending the buffer: three data bytes plus error.
        text_q = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, 8'h00, CH_QUOTE, 8'hFF, 8'h00,
                   CH_BSLASH, "n", CH_BSLASH, CH_U, "F", "F", "f", "F"};
        send_text(text_q.size() - 1);
        // A quote as the first \u byte stops digit reading, giving 0x00; the
        // closing quote carries end of input and gives only the close.
        text_q = '{CH_QUOTE, CH_BSLASH, CH_U, CH_QUOTE, "a", "B", "1", CH_QUOTE};
        send_text(text_q.size() - 1);
        // Buffer ends right after a backslash.
        text_q = '{CH_QUOTE, CH_BSLASH};
        send_text(text_q.size() - 1);
    endtask

    task automatic test_strings(input int budget);
        int stop;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            build_string($urandom_range(6, 1));
            send_text(($urandom_range(3) == 0) ? text_q.size() - 1 : -1);
        end
    endtask

    task automatic test_noise(input int budget);
        int stop;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            if ($urandom_range(1) == 0) begin
                // Arbitrary bytes, closed by end of input so the next string
                // starts from the waiting state.
                repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom_range(255)));
                send_text(text_q.size() - 1);
            end else begin
                build_string($urandom_range(4, 1));
                send_text($urandom_range(text_q.size() - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : check_results
        decoded_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result, kind", int'(m_axis_tuser), 0);
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    report_mismatch("kind", int'(m_axis_tuser), int'(want.kind));
                end
                if (m_axis_tdata !== want.data) begin
                    report_mismatch("byte", int'(m_axis_tdata), int'(want.data));
                end
                if (m_axis_tlast !== want.is_last) begin
                    report_mismatch("last", int'(m_axis_tlast), int'(want.is_last));
                end
                case (want.kind)
                    KIND_DATA:  n_data++;
                    KIND_CLOSE: n_close++;
                    default:    n_error++;
                endcase
            end
        end
    end

    // Ends a run that has stopped making progress on both channels.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, decoded_q.size());
            $display("json_string_unescape_unit verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();

        set_idling(0, 0);
        test_strings(75);
        test_noise(25);
        set_idling(53, 0);
        test_strings(75);
        test_noise(25);
        set_idling(0, 53);
        test_strings(75);
        test_noise(25);
        set_idling(28, 28);
        test_strings(75);
        test_noise(25);

        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes; checked %0d data, %0d close and %0d error transfers.",
                 bytes_sent, n_data, n_close, n_error);
        $display("Unicode escapes by UTF-8 length: %0d single, %0d double, %0d triple.",
                 n_utf8_1, n_utf8_2, n_utf8_3);
        if (mismatches == 0) begin
            $display("json_string_unescape_unit verification clean");
        end else begin
            $display("json_string_unescape_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_out_buf.sv
rtl/json_string_unescape_unit.sv
tb/tb_top.sv
